// ===== hdl/ctmm_pkg.sv =====
`default_nettype none
// ============================================================================
// ctmm_pkg
// shared types and codes of the channel min/max/step tracker
// ============================================================================
package ctmm_pkg;

    // channel field width on the stream
    localparam int CHAN_BITS    = 6;
    // configuration register index width
    localparam int CFG_IDX_BITS = 1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CHAN_MASK = 1'b0,
        CFG_GAIN_MASK = 1'b1
    } t_cfg_reg;

    // request kinds
    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    // control of the update stage
    typedef struct packed {
        t_op  op;
        logic pair_on;
        logic entry_valid;
    } t_stage_ctrl;

endpackage
`default_nettype wire

// ===== hdl/ctmm_ram.sv =====
`default_nettype none
// ============================================================================
// ctmm_ram
// simple dual-port ram, one write and one registered read per cycle
// ============================================================================
module ctmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

// ===== hdl/ctmm_update.sv =====
`default_nettype none
// ============================================================================
// ctmm_update
// statistics update of one entry and read result formatting
// ============================================================================
module ctmm_update #(
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 32
) (
    input  wire ctmm_pkg::t_stage_ctrl              i_ctrl,
    input  wire logic [SAMPLE_BITS-1:0]             i_value,
    input  wire logic [3*SAMPLE_BITS+COUNT_BITS-1:0] i_word,
    output logic      [3*SAMPLE_BITS+COUNT_BITS-1:0] o_word,
    // result: min, max, count, enable flag from the lowest bit up
    output logic      [2*SAMPLE_BITS+COUNT_BITS+2:0] o_result
);
    import ctmm_pkg::*;

    localparam int S  = SAMPLE_BITS;
    localparam int OW = SAMPLE_BITS + 1;

    logic [S-1:0]          w_min;
    logic [S-1:0]          w_max;
    logic [S-1:0]          w_prev;
    logic [COUNT_BITS-1:0] w_cnt;
    logic [S-1:0]          n_min;
    logic [S-1:0]          n_max;
    logic [COUNT_BITS-1:0] n_cnt;
    logic [OW-1:0]         w_res_min;
    logic [OW-1:0]         w_res_max;
    logic [COUNT_BITS-1:0] w_res_cnt;
    logic                  w_res_en;

    assign w_min  = i_word[S-1:0];
    assign w_max  = i_word[2*S-1:S];
    assign w_prev = i_word[3*S-1:2*S];
    assign w_cnt  = i_word[3*S+COUNT_BITS-1:3*S];

    // new entry after a sample
    always_comb begin
        if (!i_ctrl.entry_valid) begin
            // first sample of the pair always counts as a change
            n_min = i_value;
            n_max = i_value;
            n_cnt = COUNT_BITS'(1);
        end else begin
            n_min = (i_value < w_min) ? i_value : w_min;
            n_max = (i_value > w_max) ? i_value : w_max;
            if ((i_value != w_prev) && (w_cnt != {COUNT_BITS{1'b1}})) begin
                n_cnt = w_cnt + COUNT_BITS'(1);
            end else begin
                n_cnt = w_cnt;
            end
        end
    end

    assign o_word = {n_cnt, i_value, n_max, n_min};

    // read result
    always_comb begin
        if (!i_ctrl.pair_on) begin
            w_res_min = '0;
            w_res_max = '0;
            w_res_cnt = '0;
            w_res_en  = 1'b0;
        end else if (!i_ctrl.entry_valid) begin
            // no samples yet
            w_res_min = '1;
            w_res_max = '1;
            w_res_cnt = '0;
            w_res_en  = 1'b1;
        end else begin
            w_res_min = {1'b0, w_min};
            w_res_max = {1'b0, w_max};
            w_res_cnt = w_cnt;
            w_res_en  = 1'b1;
        end
    end

    assign o_result = {w_res_en, w_res_cnt, w_res_max, w_res_min};

endmodule
`default_nettype wire

// ===== hdl/ctmm_out_fifo.sv =====
`default_nettype none
// ============================================================================
// ctmm_out_fifo
// two-entry result queue between the update stage and the output stream
// ============================================================================
module ctmm_out_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_ready,
    output logic                  o_valid,
    output logic      [WIDTH-1:0] o_data,
    output logic      [1:0]       o_count
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_cnt;
    logic             n_wr_ptr;
    logic             n_rd_ptr;
    logic [1:0]       n_cnt;
    logic             w_pop;

    assign w_pop = (r_cnt != 2'd0) && i_ready;

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop ? ~r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt + {1'b0, i_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_cnt;

endmodule
`default_nettype wire

// ===== hdl/channel_min_max_step_tracker.sv =====
`default_nettype none
// ============================================================================
// channel_min_max_step_tracker
// per gain/channel minimum, maximum and change count of an adc readout
// ============================================================================
//
// channel   | direction | handshake             | contents
// ----------+-----------+-----------------------+-----------------------------
// s_axis    | in        | tvalid / tready       | sample or read request
// m_axis    | out       | tvalid / tready       | statistics of a read request
// cfg       | in        | valid / ready         | enable mask writes
//
// one request per cycle when ready; ram read on acceptance, written back next cycle
// a read result is queued in the cycle after acceptance and may leave at the next edge
// back-to-back requests to one pair are served by forwarding the write-back word
// input stalls only while the two-entry result queue would overflow (m_axis held off)
// reset is synchronous; per-entry valid bits stand in for clearing the ram, so the
// block takes requests right after reset
//
module channel_min_max_step_tracker #(
    parameter int CHANNEL_COUNT = 48,
    parameter int SAMPLE_BITS   = 12,
    parameter int COUNT_BITS    = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // request stream
    input  wire logic                     i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // tdata: gain_high, channel, sample_value (lowest bit up), zero padded
    input  wire logic [((SAMPLE_BITS+ctmm_pkg::CHAN_BITS+1+7)/8)*8-1:0] i_s_axis_tdata,
    // tuser: operation
    input  wire logic [0:0]               i_s_axis_tuser,
    // result stream
    output logic                          o_m_axis_tvalid,
    input  wire logic                     i_m_axis_tready,
    // tdata: minimum_seen, maximum_seen, change_count (lowest bit up), zero padded
    output logic [((2*SAMPLE_BITS+2+COUNT_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    // tuser: pair_enabled
    output logic      [0:0]               o_m_axis_tuser,
    // configuration writes
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [ctmm_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [((CHANNEL_COUNT > 2) ? CHANNEL_COUNT : 2)-1:0] i_cfg_data
);
    import ctmm_pkg::*;

    localparam int S          = SAMPLE_BITS;
    localparam int OW         = SAMPLE_BITS + 1;
    localparam int PAIR_COUNT = 2 * CHANNEL_COUNT;
    localparam int PAIR_BITS  = $clog2(PAIR_COUNT);
    localparam int WORD_BITS  = 3 * SAMPLE_BITS + COUNT_BITS;
    localparam int RES_BITS   = 2 * OW + COUNT_BITS + 1;
    localparam int OUT_BITS   = ((2 * OW + COUNT_BITS + 7) / 8) * 8;

    // configuration
    logic [CHANNEL_COUNT-1:0] r_chan_mask;
    logic [1:0]               r_gain_mask;

    // request decode
    logic                     w_accept;
    t_op                      w_op;
    logic                     w_gain;
    logic [CHAN_BITS-1:0]     w_chan;
    logic [S-1:0]             w_value;
    logic [63:0]              w_chan_mask_ext;
    logic                     w_on;
    logic [6:0]               w_idx_full;
    logic [PAIR_BITS-1:0]     w_rd_idx;

    // update stage
    logic                     r_s1_valid;
    t_op                      r_s1_op;
    logic                     r_s1_on;
    logic [PAIR_BITS-1:0]     r_s1_idx;
    logic [S-1:0]             r_s1_value;
    logic                     r_fwd_hit;
    logic [WORD_BITS-1:0]     r_fwd_word;
    logic                     r_rd_vld;
    logic                     n_fwd_hit;
    logic [PAIR_COUNT-1:0]    r_vld;

    logic [WORD_BITS-1:0]     w_rd_word;
    logic [WORD_BITS-1:0]     w_cur_word;
    logic [WORD_BITS-1:0]     w_new_word;
    logic [RES_BITS-1:0]      w_result;
    t_stage_ctrl              w_ctrl;
    logic                     w_wr_en;
    logic                     w_push;

    // result queue
    logic                     w_q_valid;
    logic [RES_BITS-1:0]      w_q_data;
    logic [1:0]               w_q_count;
    logic                     w_pop;
    logic [2:0]               w_occ;

    // ---------------------------------------------------------------- config
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_mask <= '1;
            r_gain_mask <= '1;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_CHAN_MASK: r_chan_mask <= i_cfg_data[CHANNEL_COUNT-1:0];
                CFG_GAIN_MASK: r_gain_mask <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- decode
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_op     = t_op'(i_s_axis_tuser[0]);
    assign w_gain   = i_s_axis_tdata[0];
    assign w_chan   = i_s_axis_tdata[CHAN_BITS:1];
    assign w_value  = i_s_axis_tdata[CHAN_BITS+S:CHAN_BITS+1];

    // out-of-range channels count as disabled
    assign w_chan_mask_ext = 64'(r_chan_mask);
    assign w_on = ({1'b0, w_chan} < 7'(CHANNEL_COUNT)) && r_gain_mask[w_gain]
                  && w_chan_mask_ext[w_chan];

    // pair index: high gain pairs follow all low gain pairs
    assign w_idx_full = {1'b0, w_chan} + (w_gain ? 7'(CHANNEL_COUNT) : 7'd0);
    assign w_rd_idx   = w_idx_full[PAIR_BITS-1:0];

    // ---------------------------------------------------------------- ram
    ctmm_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (PAIR_COUNT)
    ) u_stats_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_s1_idx),
        .i_wr_data (w_new_word),
        .i_rd_addr (w_rd_idx),
        .o_rd_data (w_rd_word)
    );

    // a write-back to the entry being read this cycle is forwarded
    assign n_fwd_hit = w_wr_en && w_accept && (r_s1_idx == w_rd_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            r_fwd_hit  <= n_fwd_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_op    <= w_op;
            r_s1_on    <= w_on;
            r_s1_idx   <= w_rd_idx;
            r_s1_value <= w_value;
            r_rd_vld   <= r_vld[w_rd_idx];
        end
        r_fwd_word <= w_new_word;
    end

    // entry valid bits: an entry never written holds the empty statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_wr_en) begin
            r_vld[r_s1_idx] <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- update
    assign w_cur_word         = r_fwd_hit ? r_fwd_word : w_rd_word;
    assign w_ctrl.op          = r_s1_op;
    assign w_ctrl.pair_on     = r_s1_on;
    assign w_ctrl.entry_valid = r_fwd_hit || r_rd_vld;

    ctmm_update #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_update (
        .i_ctrl   (w_ctrl),
        .i_value  (r_s1_value),
        .i_word   (w_cur_word),
        .o_word   (w_new_word),
        .o_result (w_result)
    );

    // samples of enabled pairs write back, reads queue a result
    assign w_wr_en = r_s1_valid && (r_s1_op == OP_SAMPLE) && r_s1_on;
    assign w_push  = r_s1_valid && (r_s1_op == OP_READ);

    // ---------------------------------------------------------------- output
    ctmm_out_fifo #(
        .WIDTH (RES_BITS)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_result),
        .i_ready (i_m_axis_tready),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .o_count (w_q_count)
    );

    assign w_pop = w_q_valid && i_m_axis_tready;

    // results queued or on their way must fit the two-entry queue
    assign w_occ = {1'b0, w_q_count} + {2'b00, w_push} - {2'b00, w_pop};
    assign o_s_axis_tready = (w_occ < 3'd2);

    assign o_m_axis_tvalid = w_q_valid;
    assign o_m_axis_tdata  = OUT_BITS'(w_q_data[RES_BITS-2:0]);
    assign o_m_axis_tuser  = w_q_data[RES_BITS-1];

    // ---------------------------------------------------------------- checks
    // result queue never overflows
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> ((w_q_count < 2'd2) || w_pop))
        else $error("result queue overflow");

    // only samples of enabled pairs modify the ram
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_s1_valid && r_s1_on && (r_s1_op != OP_READ)))
        else $error("ram written by a request that must not modify state");

    // a written entry is marked valid afterwards
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |=> r_vld[$past(r_s1_idx)])
        else $error("written entry not marked valid");

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// request/result check of the channel min/max/step tracker
// ============================================================================
//
// sample and read requests on the request stream, mask writes on the
// configuration channel
// scoreboard mirrors the per-pair statistics and queues expected read results
// both sides idle at random, one long result-side hold fills the block up
// masks are written only once every pending read has come back
// ============================================================================

module testbench;
    import ctmm_pkg::*;

    // statistics returned for one read request
    typedef struct packed {
        logic signed [12:0] minimum_seen;
        logic signed [12:0] maximum_seen;
        logic [31:0]        change_count;
        logic               pair_enabled;
    } t_pair_stats;

    class pair_stats_board;
        localparam int CHANNELS  = 48;
        localparam int EMPTY_MIN = 4096;

        // mirrored per-pair state, index = gain * CHANNELS + channel
        int          lowest[2*CHANNELS];
        int          highest[2*CHANNELS];
        int          last_sample[2*CHANNELS];
        int unsigned steps[2*CHANNELS];
        logic [47:0] chan_mask;
        logic [1:0]  gain_mask;

        t_pair_stats awaited[$];
        int          mismatches;

        function new();
            chan_mask  = '1;
            gain_mask  = '1;
            mismatches = 0;
            for (int i = 0; i < 2*CHANNELS; i++) begin
                lowest[i]      = EMPTY_MIN;
                highest[i]     = -1;
                last_sample[i] = -1;
                steps[i]       = 0;
            end
        endfunction

        function void set_register(t_cfg_reg idx, logic [47:0] value);
            if (idx == CFG_CHAN_MASK) chan_mask = value;
            else                      gain_mask = value[1:0];
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // update the mirror for an accepted request, queue a result for a read
        function void note_request(t_op op, logic gain, logic [5:0] chan,
                                   logic [11:0] value);
            logic        on;
            int          idx;
            int          sample;
            t_pair_stats want;
            on = 1'b0;
            if (chan < CHANNELS && gain_mask[gain]) on = chan_mask[chan];
            idx    = gain * CHANNELS + chan;
            sample = int'(value);
            if (op == OP_SAMPLE) begin
                if (on) begin
                    if (sample < lowest[idx])  lowest[idx]  = sample;
                    if (sample > highest[idx]) highest[idx] = sample;
                    // saturating change counter
                    if (sample != last_sample[idx] && steps[idx] != 32'hFFFF_FFFF)
                        steps[idx]++;
                    last_sample[idx] = sample;
                end
                return;
            end
            want = '0;
            if (on) begin
                // untouched pair reads -1 for both bounds
                if (lowest[idx] > highest[idx]) begin
                    want.minimum_seen = -13'sd1;
                    want.maximum_seen = -13'sd1;
                end else begin
                    want.minimum_seen = 13'(lowest[idx]);
                    want.maximum_seen = 13'(highest[idx]);
                end
                want.change_count = steps[idx];
                want.pair_enabled = 1'b1;
            end
            awaited.push_back(want);
        endfunction

        function void check_result(logic [63:0] data, logic enabled_flag);
            t_pair_stats got;
            t_pair_stats want;
            got.minimum_seen = data[12:0];
            got.maximum_seen = data[25:13];
            got.change_count = data[57:26];
            got.pair_enabled = enabled_flag;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: min %0d max %0d count %0d enabled %0b",
                             got.minimum_seen, got.maximum_seen, got.change_count,
                             got.pair_enabled);
                return;
            end
            want = awaited.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected min %0d max %0d count %0d en %0b, %s",
                             want.minimum_seen, want.maximum_seen, want.change_count,
                             want.pair_enabled,
                             $sformatf("got min %0d max %0d count %0d en %0b",
                                       got.minimum_seen, got.maximum_seen,
                                       got.change_count, got.pair_enabled));
            end
        endfunction
    endclass

    localparam int PHASE_ITEMS  = 280;
    localparam int HOT_PAIRS    = 6;
    // cycles for a trailing sample write-back to land
    localparam int SETTLE       = 4;
    // long result-side hold that fills the block up
    localparam int HOLD_CYCLES  = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata;
    logic [0:0]  i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [63:0] o_m_axis_tdata;
    logic [0:0]  o_m_axis_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index;
    logic [47:0] i_cfg_data;

    pair_stats_board board = new();

    // shared between the request and result processes
    bit hold_pending;
    bit burst;

    // last sample sent per pair, used to produce repeats and small steps
    bit [11:0] last_value [2][64];
    bit        hot_gain [HOT_PAIRS];
    bit [5:0]  hot_chan [HOT_PAIRS];

    channel_min_max_step_tracker dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // idle length: mostly none, sometimes a few cycles, rarely a long pause
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offer one request, return once it has been taken
    task automatic send_request(t_op op, logic gain, logic [5:0] chan, logic [11:0] value);
        int idle;
        idle = burst ? 0 : gap_len();
        if (idle > 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            repeat (idle - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        // tdata: gain_high, channel, sample_value, zero pad
        i_s_axis_tdata  <= {5'b0, value, chan, gain};
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_request(op, gain, chan, value);
    endtask

    // stop offering and let every pending read come back
    task automatic drain();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        // samples have no result but may still be writing back
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_register(t_cfg_reg idx, logic [47:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_register(idx, value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly a handful of hot pairs so that statistics build up,
    // sometimes any channel, a few out-of-range channels
    task automatic random_request();
        int        r;
        int        k;
        logic      gain;
        logic [5:0] chan;
        logic [11:0] value;
        t_op       op;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            k    = $urandom_range(0, HOT_PAIRS - 1);
            gain = hot_gain[k];
            chan = hot_chan[k];
        end else if (r < 93) begin
            gain = 1'($urandom_range(0, 1));
            chan = 6'($urandom_range(0, 47));
        end else begin
            gain = 1'($urandom_range(0, 1));
            chan = 6'($urandom_range(48, 63));
        end
        op = ($urandom_range(0, 99) < 30) ? OP_READ : OP_SAMPLE;
        r  = $urandom_range(0, 99);
        if (r < 35)      value = last_value[gain][chan];
        else if (r < 45) value = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
        else if (r < 65) value = 12'(last_value[gain][chan] + $urandom_range(0, 2) - 1);
        else             value = 12'($urandom_range(0, 4095));
        if (op == OP_SAMPLE) last_value[gain][chan] = value;
        send_request(op, gain, chan, value);
    endtask

    task automatic random_phase(bit with_hold);
        for (int k = 0; k < HOT_PAIRS; k++) begin
            hot_gain[k] = 1'($urandom_range(0, 1));
            hot_chan[k] = 6'($urandom_range(0, 47));
        end
        // ask the result side for its long hold while requests keep coming
        if (with_hold) hold_pending = 1'b1;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            // a stretch with no idling on either side
            burst = (n >= 120 && n < 180);
            random_request();
        end
        burst = 1'b0;
    endtask

    // result side: random ready, one long counted hold on request
    initial begin
        int stall_left;
        stall_left      = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_m_axis_tready <= 1'b1;
            end else if (burst) begin
                i_m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                stall_left = ($urandom_range(0, 99) < 65) ? 0 : gap_len();
                i_m_axis_tready <= (stall_left == 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    // result checking at the edge where the transfer happens
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            board.check_result(o_m_axis_tdata, o_m_axis_tuser[0]);
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        hold_pending    = 1'b0;
        burst           = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty pair, both value extremes, a repeated value
        send_request(OP_READ,   1'b0, 6'd0,  12'hA5A);
        send_request(OP_SAMPLE, 1'b0, 6'd0,  12'h000);
        send_request(OP_SAMPLE, 1'b0, 6'd0,  12'hFFF);
        send_request(OP_READ,   1'b0, 6'd0,  12'h5A5);
        send_request(OP_SAMPLE, 1'b0, 6'd0,  12'hFFF);
        send_request(OP_READ,   1'b0, 6'd0,  12'h000);
        // top channel on high gain
        send_request(OP_SAMPLE, 1'b1, 6'd47, 12'h800);
        send_request(OP_READ,   1'b1, 6'd47, 12'hFFF);
        // channels past the last one act as disabled
        send_request(OP_SAMPLE, 1'b0, 6'd63, 12'h064);
        send_request(OP_READ,   1'b0, 6'd63, 12'h000);
        send_request(OP_SAMPLE, 1'b1, 6'd48, 12'h123);
        send_request(OP_READ,   1'b1, 6'd48, 12'h000);
        // high gain off: sample ignored, read gives zeros
        write_register(CFG_GAIN_MASK, 48'h1);
        send_request(OP_SAMPLE, 1'b1, 6'd47, 12'h005);
        send_request(OP_READ,   1'b1, 6'd47, 12'h000);
        // back on: resumes from the stored statistics
        write_register(CFG_GAIN_MASK, 48'h3);
        send_request(OP_READ,   1'b1, 6'd47, 12'h000);

        // random phases over several mask settings
        random_phase(1'b1);
        write_register(CFG_CHAN_MASK, 48'h0);
        random_phase(1'b0);
        write_register(CFG_CHAN_MASK, 48'({$urandom, $urandom}));
        write_register(CFG_GAIN_MASK, 48'h1);
        random_phase(1'b0);
        write_register(CFG_CHAN_MASK, 48'({$urandom, $urandom}));
        write_register(CFG_GAIN_MASK, 48'h2);
        random_phase(1'b0);
        write_register(CFG_CHAN_MASK, 48'hFFFF_FFFF_FFFF);
        write_register(CFG_GAIN_MASK, 48'h0);
        random_phase(1'b0);
        write_register(CFG_GAIN_MASK, 48'h3);
        random_phase(1'b0);

        drain();
        if (board.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ctmm_pkg.sv
hdl/ctmm_ram.sv
hdl/ctmm_update.sv
hdl/ctmm_out_fifo.sv
hdl/channel_min_max_step_tracker.sv
sim/testbench.sv
